[hdl/four_bit_cpu_execute_unit_assert.svh]
// Assertion macros used by the execute unit top level.
`ifndef FOUR_BIT_CPU_EXECUTE_UNIT_ASSERT_SVH
`define FOUR_BIT_CPU_EXECUTE_UNIT_ASSERT_SVH

// Flag a condition that must never hold out of reset.
`define FBCPU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define FBCPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fbcpu_pkg.sv]
// Types and constants of the 4-bit execute unit.
`timescale 1ns / 1ps

package fbcpu_pkg;

  localparam int unsigned NIB_W = 4;
  localparam int unsigned OP_W  = 5;

  typedef logic [NIB_W-1:0] nib_t;
  typedef logic [OP_W-1:0]  opcode_t;

  // Opcodes
  localparam opcode_t OP_ADD_A  = 5'd0;
  localparam opcode_t OP_MOV_AB = 5'd1;
  localparam opcode_t OP_IN_A   = 5'd2;
  localparam opcode_t OP_MOV_AI = 5'd3;
  localparam opcode_t OP_MOV_BA = 5'd4;
  localparam opcode_t OP_ADD_B  = 5'd5;
  localparam opcode_t OP_IN_B   = 5'd6;
  localparam opcode_t OP_MOV_BI = 5'd7;
  localparam opcode_t OP_SUB_A  = 5'd8;
  localparam opcode_t OP_OUT_B  = 5'd9;
  localparam opcode_t OP_SUB_B  = 5'd10;
  localparam opcode_t OP_OUT_I  = 5'd11;
  localparam opcode_t OP_AND_A  = 5'd12;
  localparam opcode_t OP_AND_B  = 5'd13;
  localparam opcode_t OP_JNC    = 5'd14;
  localparam opcode_t OP_JMP    = 5'd15;
  localparam opcode_t OP_OR_A   = 5'd16;
  localparam opcode_t OP_OR_B   = 5'd17;
  localparam opcode_t OP_XOR_A  = 5'd18;
  localparam opcode_t OP_XOR_B  = 5'd19;
  localparam opcode_t OP_CLR_C  = 5'd20;
  localparam opcode_t OP_SHL_A  = 5'd21;
  localparam opcode_t OP_SHL_B  = 5'd22;
  localparam opcode_t OP_SHR_A  = 5'd23;
  localparam opcode_t OP_SHR_B  = 5'd24;
  localparam opcode_t OP_NOT_A  = 5'd25;
  localparam opcode_t OP_NOT_B  = 5'd26;
  localparam opcode_t OP_JC     = 5'd27;

  // Destination of the result
  typedef enum logic [1:0] {
    DST_NONE,
    DST_A,
    DST_B,
    DST_OUT
  } dst_t;

  // Second operand source
  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_A,
    SRC_B
  } src_t;

  // Function applied to destination and operand
  typedef enum logic [3:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_SHL,
    ALU_SHR,
    ALU_NOT
  } alu_t;

  // Next program counter; PC_HOLD marks an instruction that changes nothing
  typedef enum logic [2:0] {
    PC_INC,
    PC_JMP,
    PC_JNC,
    PC_JC,
    PC_HOLD
  } pc_mode_t;

  // Decoded instruction as queued between front and back
  typedef struct packed {
    dst_t     dst;
    src_t     src;
    alu_t     alu;
    pc_mode_t pc_mode;
    nib_t     lit;
  } dec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/fbcpu_in_if.sv]
// Instruction channel: opcode, immediate and input-port values.
`timescale 1ns / 1ps

interface fbcpu_in_if;
  logic                valid;
  logic                ready;
  fbcpu_pkg::opcode_t  op;
  fbcpu_pkg::nib_t     immediate;
  fbcpu_pkg::nib_t     in_port_a;
  fbcpu_pkg::nib_t     in_port_b;

  modport source (output valid, output op, output immediate, output in_port_a,
                  output in_port_b, input ready);
  modport sink   (input valid, input op, input immediate, input in_port_a,
                  input in_port_b, output ready);
endinterface

[hdl/fbcpu_out_if.sv]
// Result channel: machine state after each instruction.
`timescale 1ns / 1ps

interface fbcpu_out_if;
  logic            valid;
  logic            ready;
  fbcpu_pkg::nib_t pc_value;
  fbcpu_pkg::nib_t reg_a_value;
  fbcpu_pkg::nib_t reg_b_value;
  logic            carry_value;
  fbcpu_pkg::nib_t out_port_value;

  modport source (output valid, output pc_value, output reg_a_value,
                  output reg_b_value, output carry_value, output out_port_value,
                  input ready);
  modport sink   (input valid, input pc_value, input reg_a_value,
                  input reg_b_value, input carry_value, input out_port_value,
                  output ready);
endinterface

[hdl/four_bit_cpu_execute_unit.sv]
// Top level of the 4-bit CPU execute unit.
`timescale 1ns / 1ps

// Executes one instruction per input word and returns one word holding the
// program counter, registers A and B, the carry and the output latch after
// it. Sustained rate is one instruction per cycle while results are taken
// promptly. An accepted instruction passes through the decode queue and then
// the execute loop on the A, B, counter and carry registers, which double as
// the result register. The queue of QUEUE_DEPTH entries lets the front keep
// accepting while a result waits to be taken.
`include "four_bit_cpu_execute_unit_assert.svh"

module four_bit_cpu_execute_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  fbcpu_in_if.sink     in_ch,
  fbcpu_out_if.source  out_ch
);

  logic               push;
  logic               pop;
  fbcpu_pkg::dec_t    push_dec;
  fbcpu_pkg::dec_t    head;
  fbcpu_pkg::q_stat_t q_stat;

  // Decode incoming words
  fbcpu_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .dec    (push_dec)
  );

  // Buffer decoded words
  fbcpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_dec (push_dec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Execute and hold the machine state
  fbcpu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `FBCPU_ASSERT_NEVER(a_queue_stat, q_stat.full && q_stat.empty, "queue full and empty")
  `FBCPU_ASSERT_NEXT(a_pop_result, pop, out_ch.valid, "executed word not presented")
  `FBCPU_ASSERT_NEXT(a_jump_target, pop && head.pc_mode == fbcpu_pkg::PC_JMP, out_ch.pc_value == $past(head.lit), "jump target lost")

endmodule

[hdl/fbcpu_front.sv]
// Front end: accepts instruction words and decodes them into queue entries.
`timescale 1ns / 1ps

module fbcpu_front (
  fbcpu_in_if.sink         in_ch,
  input  fbcpu_pkg::q_stat_t q_stat,
  output logic             push,
  output fbcpu_pkg::dec_t  dec
);

  // Take a word whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Classify the opcode
  always_comb begin
    dec.dst     = fbcpu_pkg::DST_NONE;
    dec.src     = fbcpu_pkg::SRC_LIT;
    dec.alu     = fbcpu_pkg::ALU_PASS;
    dec.pc_mode = fbcpu_pkg::PC_INC;
    dec.lit     = in_ch.immediate;
    unique case (in_ch.op)
      fbcpu_pkg::OP_ADD_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_ADD; end
      fbcpu_pkg::OP_MOV_AB: begin dec.dst = fbcpu_pkg::DST_A; dec.src = fbcpu_pkg::SRC_B; end
      fbcpu_pkg::OP_IN_A:   begin dec.dst = fbcpu_pkg::DST_A; dec.lit = in_ch.in_port_a; end
      fbcpu_pkg::OP_MOV_AI: begin dec.dst = fbcpu_pkg::DST_A; end
      fbcpu_pkg::OP_MOV_BA: begin dec.dst = fbcpu_pkg::DST_B; dec.src = fbcpu_pkg::SRC_A; end
      fbcpu_pkg::OP_ADD_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_ADD; end
      fbcpu_pkg::OP_IN_B:   begin dec.dst = fbcpu_pkg::DST_B; dec.lit = in_ch.in_port_b; end
      fbcpu_pkg::OP_MOV_BI: begin dec.dst = fbcpu_pkg::DST_B; end
      fbcpu_pkg::OP_SUB_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_SUB; end
      fbcpu_pkg::OP_OUT_B:  begin dec.dst = fbcpu_pkg::DST_OUT; dec.src = fbcpu_pkg::SRC_B; end
      fbcpu_pkg::OP_SUB_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_SUB; end
      fbcpu_pkg::OP_OUT_I:  begin dec.dst = fbcpu_pkg::DST_OUT; end
      fbcpu_pkg::OP_AND_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_AND; end
      fbcpu_pkg::OP_AND_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_AND; end
      fbcpu_pkg::OP_JNC:    begin dec.pc_mode = fbcpu_pkg::PC_JNC; end
      fbcpu_pkg::OP_JMP:    begin dec.pc_mode = fbcpu_pkg::PC_JMP; end
      fbcpu_pkg::OP_OR_A:   begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_OR; end
      fbcpu_pkg::OP_OR_B:   begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_OR; end
      fbcpu_pkg::OP_XOR_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_XOR; end
      fbcpu_pkg::OP_XOR_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_XOR; end
      fbcpu_pkg::OP_CLR_C:  begin end
      fbcpu_pkg::OP_SHL_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_SHL; end
      fbcpu_pkg::OP_SHL_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_SHL; end
      fbcpu_pkg::OP_SHR_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_SHR; end
      fbcpu_pkg::OP_SHR_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_SHR; end
      fbcpu_pkg::OP_NOT_A:  begin dec.dst = fbcpu_pkg::DST_A; dec.alu = fbcpu_pkg::ALU_NOT; end
      fbcpu_pkg::OP_NOT_B:  begin dec.dst = fbcpu_pkg::DST_B; dec.alu = fbcpu_pkg::ALU_NOT; end
      fbcpu_pkg::OP_JC:     begin dec.pc_mode = fbcpu_pkg::PC_JC; end
      // unused opcodes leave all state alone
      default:              begin dec.pc_mode = fbcpu_pkg::PC_HOLD; end
    endcase
  end

endmodule

[hdl/fbcpu_queue.sv]
// Small FIFO of decoded instructions between front and back.
`timescale 1ns / 1ps

module fbcpu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fbcpu_pkg::dec_t    push_dec,
  input  logic               pop,
  output fbcpu_pkg::dec_t    head,
  output fbcpu_pkg::q_stat_t q_stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fbcpu_pkg::dec_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_dec;
    end
  end

endmodule

[hdl/fbcpu_back.sv]
// Back end: executes queued instructions and presents the machine state.
`timescale 1ns / 1ps

module fbcpu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fbcpu_pkg::q_stat_t q_stat,
  input  fbcpu_pkg::dec_t    head,
  output logic               pop,
  fbcpu_out_if.source        out_ch
);

  fbcpu_pkg::nib_t reg_a_r, reg_a_nxt;
  fbcpu_pkg::nib_t reg_b_r, reg_b_nxt;
  fbcpu_pkg::nib_t pc_r, pc_nxt;
  fbcpu_pkg::nib_t out_latch_r, out_latch_nxt;
  logic            carry_r, carry_nxt;
  logic            out_valid_r, out_valid_nxt;

  fbcpu_pkg::nib_t base;
  fbcpu_pkg::nib_t opd;
  fbcpu_pkg::nib_t res;
  logic            res_cy;
  logic [4:0]      sum;
  logic [4:0]      diff;

  // Execute when the state word is free or being taken
  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // Pick operands
  always_comb begin
    base = (head.dst == fbcpu_pkg::DST_B) ? reg_b_r : reg_a_r;
    case (head.src)
      fbcpu_pkg::SRC_A: opd = reg_a_r;
      fbcpu_pkg::SRC_B: opd = reg_b_r;
      default:          opd = head.lit;
    endcase
  end

  assign sum  = {1'b0, base} + {1'b0, opd};
  assign diff = {1'b0, base} - {1'b0, opd};

  // ALU; carry is set only by add, subtract and shift left
  always_comb begin
    res_cy = 1'b0;
    case (head.alu)
      fbcpu_pkg::ALU_ADD: begin res = sum[3:0];  res_cy = sum[4]; end
      fbcpu_pkg::ALU_SUB: begin res = diff[3:0]; res_cy = diff[4]; end
      fbcpu_pkg::ALU_AND: res = base & opd;
      fbcpu_pkg::ALU_OR:  res = base | opd;
      fbcpu_pkg::ALU_XOR: res = base ^ opd;
      fbcpu_pkg::ALU_SHL: begin res = {base[2:0], 1'b0}; res_cy = base[3]; end
      fbcpu_pkg::ALU_SHR: res = {1'b0, base[3:1]};
      fbcpu_pkg::ALU_NOT: res = ~base;
      default:            res = opd;
    endcase
  end

  // Update architectural state and the result flag
  always_comb begin
    reg_a_nxt     = reg_a_r;
    reg_b_nxt     = reg_b_r;
    pc_nxt        = pc_r;
    out_latch_nxt = out_latch_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      case (head.dst)
        fbcpu_pkg::DST_A:   reg_a_nxt = res;
        fbcpu_pkg::DST_B:   reg_b_nxt = res;
        fbcpu_pkg::DST_OUT: out_latch_nxt = res;
        default:            ;
      endcase
      if (head.pc_mode != fbcpu_pkg::PC_HOLD) begin
        carry_nxt = res_cy;
      end
      case (head.pc_mode)
        fbcpu_pkg::PC_JMP:  pc_nxt = head.lit;
        fbcpu_pkg::PC_JNC:  pc_nxt = carry_r ? pc_r + 4'd1 : head.lit;
        fbcpu_pkg::PC_JC:   pc_nxt = carry_r ? head.lit : pc_r + 4'd1;
        fbcpu_pkg::PC_HOLD: pc_nxt = pc_r;
        default:            pc_nxt = pc_r + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_a_r     <= '0;
      reg_b_r     <= '0;
      pc_r        <= '0;
      out_latch_r <= '0;
      carry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reg_a_r     <= reg_a_nxt;
      reg_b_r     <= reg_b_nxt;
      pc_r        <= pc_nxt;
      out_latch_r <= out_latch_nxt;
      carry_r     <= carry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Present the state as the result word
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pc_value       = pc_r;
  assign out_ch.reg_a_value    = reg_a_r;
  assign out_ch.reg_b_value    = reg_b_r;
  assign out_ch.carry_value    = carry_r;
  assign out_ch.out_port_value = out_latch_r;

endmodule

[verif/tb.sv]
// Self-checking testbench for the 4-bit CPU execute unit.
`timescale 1ns / 1ps

// Machine state carried by one result word
typedef struct packed {
  fbcpu_pkg::nib_t count_val;
  fbcpu_pkg::nib_t reg_a_val;
  fbcpu_pkg::nib_t reg_b_val;
  logic            carry_val;
  fbcpu_pkg::nib_t out_val;
} cpu_state_t;

// Tracks the machine state and the state words still owed by the block
class cpu_scoreboard;
  cpu_state_t  cur;
  cpu_state_t  owed_states[$];
  int unsigned noted;
  int unsigned unused_ops;
  int unsigned jumps_taken;
  int unsigned checked;
  int unsigned mismatches;

  function new();
    cur         = '0;
    noted       = 0;
    unused_ops  = 0;
    jumps_taken = 0;
    checked     = 0;
    mismatches  = 0;
  endfunction

  // Execute one accepted instruction word and queue the state it leaves
  function void note_instr(fbcpu_pkg::opcode_t op, fbcpu_pkg::nib_t imm,
                           fbcpu_pkg::nib_t pa, fbcpu_pkg::nib_t pb);
    logic [fbcpu_pkg::NIB_W:0] wide;
    logic                      cy;
    fbcpu_pkg::nib_t           next_count;
    noted++;
    if (op > fbcpu_pkg::OP_JC) begin
      // unused opcodes leave every register alone, counter and carry too
      unused_ops++;
    end else begin
      next_count = cur.count_val + 1'b1;
      cy         = 1'b0;
      case (op)
        fbcpu_pkg::OP_ADD_A: begin
          wide          = {1'b0, cur.reg_a_val} + {1'b0, imm};
          cy            = wide[fbcpu_pkg::NIB_W];
          cur.reg_a_val = wide[fbcpu_pkg::NIB_W-1:0];
        end
        fbcpu_pkg::OP_MOV_AB: cur.reg_a_val = cur.reg_b_val;
        fbcpu_pkg::OP_IN_A:   cur.reg_a_val = pa;
        fbcpu_pkg::OP_MOV_AI: cur.reg_a_val = imm;
        fbcpu_pkg::OP_MOV_BA: cur.reg_b_val = cur.reg_a_val;
        fbcpu_pkg::OP_ADD_B: begin
          wide          = {1'b0, cur.reg_b_val} + {1'b0, imm};
          cy            = wide[fbcpu_pkg::NIB_W];
          cur.reg_b_val = wide[fbcpu_pkg::NIB_W-1:0];
        end
        fbcpu_pkg::OP_IN_B:   cur.reg_b_val = pb;
        fbcpu_pkg::OP_MOV_BI: cur.reg_b_val = imm;
        fbcpu_pkg::OP_SUB_A: begin
          cy            = (cur.reg_a_val < imm);
          cur.reg_a_val = cur.reg_a_val - imm;
        end
        fbcpu_pkg::OP_OUT_B:  cur.out_val = cur.reg_b_val;
        fbcpu_pkg::OP_SUB_B: begin
          cy            = (cur.reg_b_val < imm);
          cur.reg_b_val = cur.reg_b_val - imm;
        end
        fbcpu_pkg::OP_OUT_I:  cur.out_val = imm;
        fbcpu_pkg::OP_AND_A:  cur.reg_a_val = cur.reg_a_val & imm;
        fbcpu_pkg::OP_AND_B:  cur.reg_b_val = cur.reg_b_val & imm;
        fbcpu_pkg::OP_JNC: begin
          if (!cur.carry_val) begin
            next_count = imm;
            jumps_taken++;
          end
        end
        fbcpu_pkg::OP_JMP:    next_count = imm;
        fbcpu_pkg::OP_OR_A:   cur.reg_a_val = cur.reg_a_val | imm;
        fbcpu_pkg::OP_OR_B:   cur.reg_b_val = cur.reg_b_val | imm;
        fbcpu_pkg::OP_XOR_A:  cur.reg_a_val = cur.reg_a_val ^ imm;
        fbcpu_pkg::OP_XOR_B:  cur.reg_b_val = cur.reg_b_val ^ imm;
        fbcpu_pkg::OP_CLR_C:  cy = 1'b0;
        fbcpu_pkg::OP_SHL_A: begin
          cy            = cur.reg_a_val[fbcpu_pkg::NIB_W-1];
          cur.reg_a_val = cur.reg_a_val << 1;
        end
        fbcpu_pkg::OP_SHL_B: begin
          cy            = cur.reg_b_val[fbcpu_pkg::NIB_W-1];
          cur.reg_b_val = cur.reg_b_val << 1;
        end
        fbcpu_pkg::OP_SHR_A:  cur.reg_a_val = cur.reg_a_val >> 1;
        fbcpu_pkg::OP_SHR_B:  cur.reg_b_val = cur.reg_b_val >> 1;
        fbcpu_pkg::OP_NOT_A:  cur.reg_a_val = ~cur.reg_a_val;
        fbcpu_pkg::OP_NOT_B:  cur.reg_b_val = ~cur.reg_b_val;
        fbcpu_pkg::OP_JC: begin
          if (cur.carry_val) begin
            next_count = imm;
            jumps_taken++;
          end
        end
        default:   cy = 1'b0;
      endcase
      cur.count_val = next_count;
      cur.carry_val = cy;
    end
    owed_states = {owed_states, cur};
  endfunction

  // Compare a returned state word with the oldest one owed
  function void check_state(cpu_state_t got);
    cpu_state_t want;
    if (owed_states.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected state word: count %0d a %0d b %0d c %0d out %0d",
                 got.count_val, got.reg_a_val, got.reg_b_val, got.carry_val,
                 got.out_val);
      return;
    end
    want = owed_states.pop_front();
    checked++;
    if (got.count_val !== want.count_val || got.reg_a_val !== want.reg_a_val ||
        got.reg_b_val !== want.reg_b_val || got.carry_val !== want.carry_val ||
        got.out_val !== want.out_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: want count %0d a %0d b %0d c %0d out %0d, got %0d %0d %0d %0d %0d",
                 checked, want.count_val, want.reg_a_val, want.reg_b_val,
                 want.carry_val, want.out_val, got.count_val, got.reg_a_val,
                 got.reg_b_val, got.carry_val, got.out_val);
    end
  endfunction
endclass

module tb;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_LEN    = 200;
  localparam int unsigned RAND_PHASE  = 170;

  // First and last of the opcodes that do nothing
  localparam fbcpu_pkg::opcode_t OP_SPARE_LO = 5'd28;
  localparam fbcpu_pkg::opcode_t OP_SPARE_HI = 5'd31;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fbcpu_in_if  in_bus ();
  fbcpu_out_if out_bus ();

  four_bit_cpu_execute_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  cpu_scoreboard sb;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   words_taken   = 0;
  int unsigned   hold_left     = 0;
  bit            hold_done     = 1'b0;
  int unsigned   quiet_cycles  = 0;

  // Free-running clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note every instruction word the block takes
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_instr(in_bus.op, in_bus.immediate, in_bus.in_port_a, in_bus.in_port_b);
  end

  // Check every state word the block hands over
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_state('{out_bus.pc_value, out_bus.reg_a_value, out_bus.reg_b_value,
                       out_bus.carry_value, out_bus.out_port_value});
  end

  // Drive result ready: random idling, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        words_taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && words_taken == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one instruction word after a random gap and hold it until taken
  task automatic send_instr(fbcpu_pkg::opcode_t op, fbcpu_pkg::nib_t imm,
                            fbcpu_pkg::nib_t pa, fbcpu_pkg::nib_t pb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.op        <= op;
    in_bus.immediate <= imm;
    in_bus.in_port_a <= pa;
    in_bus.in_port_b <= pb;
    @(posedge clk);
    while (!in_bus.ready)
      @(posedge clk);
  endtask

  // Random programs: mostly defined opcodes, some unused ones
  task automatic send_random(int unsigned count);
    fbcpu_pkg::opcode_t op;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8)
        op = fbcpu_pkg::opcode_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      else
        op = fbcpu_pkg::opcode_t'($urandom_range(fbcpu_pkg::OP_JC, fbcpu_pkg::OP_ADD_A));
      send_instr(op, fbcpu_pkg::nib_t'($urandom_range(15)),
                 fbcpu_pkg::nib_t'($urandom_range(15)),
                 fbcpu_pkg::nib_t'($urandom_range(15)));
    end
  endtask

  initial begin
    sb = new();
    in_bus.valid     <= 1'b0;
    in_bus.op        <= '0;
    in_bus.immediate <= '0;
    in_bus.in_port_a <= '0;
    in_bus.in_port_b <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 80;

    // Directed: overflow, borrow, taken and untaken jumps, counter wrap
    send_instr(fbcpu_pkg::OP_MOV_AI, 4'd15, 4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_ADD_A,  4'd1,  4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_JC,     4'd5,  4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_JNC,    4'd9,  4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_MOV_BI, 4'd15, 4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_ADD_B,  4'd15, 4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_JNC,    4'd0,  4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_SUB_A,  4'd1,  4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_JC,     4'd15, 4'd0, 4'd0);
    send_instr(fbcpu_pkg::OP_SHL_A,  4'd0,  4'd0, 4'd0);
    // unused opcodes with carry set must leave it set
    send_instr(OP_SPARE_HI, 4'd15, 4'd15, 4'd15);
    send_instr(OP_SPARE_LO, 4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_IN_A,   4'd0,  4'd15, 4'd0);
    send_instr(fbcpu_pkg::OP_IN_B,   4'd0,  4'd0,  4'd15);
    send_instr(fbcpu_pkg::OP_OUT_B,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_OUT_I,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_SUB_B,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_AND_A,  4'd5,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_AND_B,  4'd10, 4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_OR_A,   4'd8,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_OR_B,   4'd1,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_XOR_A,  4'd15, 4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_XOR_B,  4'd6,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_SHL_B,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_CLR_C,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_SHR_A,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_SHR_B,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_NOT_A,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_NOT_B,  4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_MOV_BA, 4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_MOV_AB, 4'd0,  4'd0,  4'd0);
    send_instr(fbcpu_pkg::OP_JMP,    4'd0,  4'd0,  4'd0);

    // Random: slow receiver, then slow sender, then full rate
    send_random(RAND_PHASE);
    send_idle_pct = 80;
    recv_idle_pct = 38;
    send_random(RAND_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RAND_PHASE);
    in_bus.valid <= 1'b0;

    // Drain, then keep watching for any stray word
    while (sb.owed_states.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d instructions (%0d unused opcodes, %0d conditional jumps taken),",
             sb.noted, sb.unused_ops, sb.jumps_taken);
    $display("checked %0d state words under three idling mixes and one long stall; %0d bad",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_states.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
